// ===== design/wbpd_pkg.sv =====
// Shared types and constants of the weighted Bernoulli pair distance block.
// Depends on nothing; every other file of the block imports it.
`default_nettype none

package wbpd_pkg;

	// Fixed-point format of probabilities, weights and distances (Q1.16).
	localparam int FRAC_BITS = 16;
	localparam int PROB_W    = FRAC_BITS + 1;
	localparam logic [PROB_W-1:0] ONE_FX = PROB_W'(1) << FRAC_BITS;

	// Accumulator widths.
	localparam int COUNT_W = 13;
	localparam int SUM_W   = 29;
	localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
	localparam logic [SUM_W-1:0]   SUM_MAX   = '1;

	// Configuration port.
	localparam int ADDR_W = 3;
	localparam int DATA_W = 32;
	localparam logic [0:0] REG_COMMON_FLOOR = 1'b0;
	localparam logic [COUNT_W-1:0] COMMON_FLOOR_RESET = COUNT_W'(1);

	// Depth of the queue between the accumulator and the divider.
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
	localparam int QFILL_W     = $clog2(QUEUE_DEPTH + 1);

	// Result codes.
	typedef enum logic [1:0] {
		OUT_COMPUTED    = 2'd0,
		OUT_DIAGONAL    = 2'd1,
		OUT_TOO_FEW     = 2'd2,
		OUT_ZERO_WEIGHT = 2'd3
	} outcome_t;

	// Final sums of one read pair, handed from the front to the divider.
	typedef struct packed {
		logic               diag;
		logic [COUNT_W-1:0] common_count;
		logic [SUM_W-1:0]   weight_sum;
		logic [SUM_W-1:0]   delta_sum;
	} pair_sums_t;

endpackage

`default_nettype wire

// ===== design/wbpd_front.sv =====
// Front part: takes one column per cycle unless stalled, forms weights and
// products in a three-stage pipeline and accumulates the pair sums. Depends on wbpd_pkg.
`default_nettype none

module wbpd_front (
	input  logic                      clk,
	input  logic                      arst_n,
	input  logic                      in_valid,
	output logic                      in_stall,
	input  logic [wbpd_pkg::PROB_W-1:0] prob_first,
	input  logic [wbpd_pkg::PROB_W-1:0] prob_second,
	input  logic                      first_missing,
	input  logic                      second_missing,
	input  logic                      same_read,
	input  logic                      last_column,
	output logic                      push,
	output wbpd_pkg::pair_sums_t      push_data,
	input  logic                      q_full
);
	import wbpd_pkg::*;

	// A value above one counts as exactly one.
	function automatic logic [PROB_W-1:0] clamp_prob(input logic [PROB_W-1:0] v);
		return (v > ONE_FX) ? ONE_FX : v;
	endfunction

	// Weight |2p-1| of a clamped probability.
	function automatic logic [PROB_W-1:0] weight_of(input logic [PROB_W-1:0] p);
		logic [PROB_W:0] twice;
		twice = {p, 1'b0};
		return (twice >= {1'b0, ONE_FX}) ? PROB_W'(twice - {1'b0, ONE_FX})
		                                 : PROB_W'({1'b0, ONE_FX} - twice);
	endfunction

	// Saturating accumulate.
	function automatic logic [SUM_W-1:0] sat_add(input logic [SUM_W-1:0] a,
	                                             input logic [PROB_W-1:0] b);
		logic [SUM_W:0] s;
		s = {1'b0, a} + (SUM_W+1)'(b);
		return (s > {1'b0, SUM_MAX}) ? SUM_MAX : s[SUM_W-1:0];
	endfunction

	logic adv;
	logic retire;

	logic v_s1, v_s2, v_s3;
	logic pres_s1, pres_s2, pres_s3;
	logic last_s1, last_s2, last_s3;
	logic diag_s1, diag_s2, diag_s3;
	logic [PROB_W-1:0] p1_s1, p2_s1, w1_s1, w2_s1;
	logic [PROB_W-1:0] ww_s2, pp_s2;
	logic [PROB_W:0]   psum_s2;
	logic [PROB_W-1:0] ww_s3, term_s3;

	logic [2*PROB_W-1:0] ww_full, pp_full, term_full;
	logic [PROB_W:0]     prod2, delta_raw;
	logic [PROB_W-1:0]   delta;

	logic [COUNT_W-1:0] count_q, count_next;
	logic [SUM_W-1:0]   wsum_q, wsum_next, dsum_q, dsum_next;

	// The pipeline moves unless a finished pair cannot enter the queue.
	assign adv      = !(v_s3 && last_s3 && q_full);
	assign in_stall = !adv;
	assign retire   = v_s3 && adv;

	// Valid bits of the three stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
		end else if (adv) begin
			v_s1 <= in_valid;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
		end
	end

	// Stage 1 registers clamped probabilities, their weights and the flags.
	always_ff @(posedge clk) begin
		if (adv) begin
			p1_s1   <= clamp_prob(prob_first);
			p2_s1   <= clamp_prob(prob_second);
			w1_s1   <= weight_of(clamp_prob(prob_first));
			w2_s1   <= weight_of(clamp_prob(prob_second));
			pres_s1 <= !first_missing && !second_missing;
			last_s1 <= last_column;
			diag_s1 <= same_read;
		end
	end

	// Stage 2 registers the weight product, the probability product and the probability sum.
	assign ww_full = w1_s1 * w2_s1;
	assign pp_full = p1_s1 * p2_s1;

	always_ff @(posedge clk) begin
		if (adv) begin
			ww_s2   <= ww_full[FRAC_BITS +: PROB_W];
			pp_s2   <= pp_full[FRAC_BITS +: PROB_W];
			psum_s2 <= {1'b0, p1_s1} + {1'b0, p2_s1};
			pres_s2 <= pres_s1;
			last_s2 <= last_s1;
			diag_s2 <= diag_s1;
		end
	end

	// Stage 3 forms delta = p1+p2-2*p1*p2, clamped to [0,1], and weights it.
	assign prod2     = {pp_s2, 1'b0};
	assign delta_raw = (psum_s2 >= prod2) ? (psum_s2 - prod2) : '0;
	assign delta     = (delta_raw > {1'b0, ONE_FX}) ? ONE_FX : delta_raw[PROB_W-1:0];
	assign term_full = ww_s2 * delta;

	always_ff @(posedge clk) begin
		if (adv) begin
			ww_s3   <= ww_s2;
			term_s3 <= term_full[FRAC_BITS +: PROB_W];
			pres_s3 <= pres_s2;
			last_s3 <= last_s2;
			diag_s3 <= diag_s2;
		end
	end

	// Sums including the column in stage 3.
	always_comb begin
		count_next = count_q;
		wsum_next  = wsum_q;
		dsum_next  = dsum_q;
		if (pres_s3) begin
			if (count_q != COUNT_MAX) begin
				count_next = count_q + COUNT_W'(1);
			end
			wsum_next = sat_add(wsum_q, ww_s3);
			dsum_next = sat_add(dsum_q, term_s3);
		end
	end

	// Accumulators clear after the last column of a pair.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			wsum_q  <= '0;
			dsum_q  <= '0;
		end else if (retire) begin
			if (last_s3) begin
				count_q <= '0;
				wsum_q  <= '0;
				dsum_q  <= '0;
			end else begin
				count_q <= count_next;
				wsum_q  <= wsum_next;
				dsum_q  <= dsum_next;
			end
		end
	end

	// A finished pair goes to the queue with its final sums.
	assign push                   = retire && last_s3;
	assign push_data.diag         = diag_s3;
	assign push_data.common_count = count_next;
	assign push_data.weight_sum   = wsum_next;
	assign push_data.delta_sum    = dsum_next;

	// The sums start from zero for the pair after a last column.
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		(retire && last_s3) |=> (count_q == '0 && wsum_q == '0 && dsum_q == '0))
		else $error("accumulators not cleared after last column");

	// The weighted delta sum never exceeds the weight sum.
	a_delta_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (push_data.delta_sum <= push_data.weight_sum))
		else $error("delta sum above weight sum");

endmodule

`default_nettype wire

// ===== design/wbpd_queue.sv =====
// Short queue of finished pair sums between the accumulator and the divider.
// Depends on wbpd_pkg.
`default_nettype none

module wbpd_queue (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 push,
	input  wbpd_pkg::pair_sums_t push_data,
	output logic                 full,
	input  logic                 pop,
	output logic                 pop_valid,
	output wbpd_pkg::pair_sums_t pop_data
);
	import wbpd_pkg::*;

	pair_sums_t         entry_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [QFILL_W-1:0] fill_q;

	assign full      = (fill_q == QFILL_W'(QUEUE_DEPTH));
	assign pop_valid = (fill_q != '0);
	assign pop_data  = entry_q[rd_ptr_q];

	// Entry storage.
	always_ff @(posedge clk) begin
		if (push) begin
			entry_q[wr_ptr_q] <= push_data;
		end
	end

	// Pointers wrap at the queue depth.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
				                                                   : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0
				                                                   : rd_ptr_q + QPTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + QFILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - QFILL_W'(1);
			end
		end
	end

	// The front never pushes into a full queue, and nothing pops an empty one.
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		(push |-> !full) and (pop |-> pop_valid))
		else $error("queue overflow or underflow");

endmodule

`default_nettype wire

// ===== design/wbpd_back.sv =====
// Back part: classifies a finished pair and divides the two sums with a
// bit-serial restoring divider, then holds the result. Depends on wbpd_pkg.
`default_nettype none

module wbpd_back (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        q_valid,
	input  wbpd_pkg::pair_sums_t        q_data,
	output logic                        q_pop,
	input  logic [wbpd_pkg::COUNT_W-1:0] common_floor,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [wbpd_pkg::PROB_W-1:0] distance,
	output logic [1:0]                  outcome
);
	import wbpd_pkg::*;

	localparam int QUO_W  = FRAC_BITS + 1;
	localparam int STEP_W = $clog2(QUO_W);
	localparam int REM_W  = SUM_W + 1;

	typedef enum logic [2:0] {
		ST_IDLE = 3'b001,
		ST_DIV  = 3'b010,
		ST_DONE = 3'b100
	} div_state_t;

	div_state_t        state_q;
	logic [STEP_W-1:0] step_q;
	logic [REM_W-1:0]  rem_q;
	logic [SUM_W-1:0]  div_q;
	logic [QUO_W-1:0]  quo_q;

	logic              out_valid_q;
	logic [PROB_W-1:0] distance_q;
	outcome_t          outcome_q;

	logic              out_free;
	logic              load;
	outcome_t          load_code;
	logic [PROB_W-1:0] load_dist;
	logic              special;
	outcome_t          special_code;
	logic [REM_W-1:0]  trial;
	logic              fits;

	assign out_free = !out_valid_q || !out_stall;
	assign q_pop    = (state_q == ST_IDLE) && q_valid && out_free;

	// Cases that give no quotient, in priority order.
	always_comb begin
		special      = 1'b1;
		special_code = OUT_DIAGONAL;
		if (q_data.diag) begin
			special_code = OUT_DIAGONAL;
		end else if (q_data.common_count < common_floor) begin
			special_code = OUT_TOO_FEW;
		end else if (q_data.weight_sum == '0) begin
			special_code = OUT_ZERO_WEIGHT;
		end else begin
			special = 1'b0;
		end
	end

	// One quotient bit a cycle; the first step takes the sum unshifted.
	assign trial = (step_q == '0) ? rem_q : {rem_q[REM_W-2:0], 1'b0};
	assign fits  = (trial >= {1'b0, div_q});

	// Result register load.
	always_comb begin
		load      = 1'b0;
		load_code = OUT_COMPUTED;
		load_dist = '0;
		if (q_pop && special) begin
			load      = 1'b1;
			load_code = special_code;
		end else if ((state_q == ST_DONE) && out_free) begin
			load      = 1'b1;
			load_dist = (quo_q > QUO_W'(ONE_FX)) ? ONE_FX : PROB_W'(quo_q);
		end
	end

	// Divider sequencer.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			step_q  <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (q_pop && !special) begin
						state_q <= ST_DIV;
						step_q  <= '0;
					end
				end
				ST_DIV: begin
					if (step_q == STEP_W'(QUO_W - 1)) begin
						state_q <= ST_DONE;
					end
					step_q <= step_q + STEP_W'(1);
				end
				ST_DONE: begin
					if (out_free) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Divider datapath.
	always_ff @(posedge clk) begin
		if (q_pop) begin
			rem_q <= {1'b0, q_data.delta_sum};
			div_q <= q_data.weight_sum;
			quo_q <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q <= fits ? (trial - {1'b0, div_q}) : trial;
			quo_q <= {quo_q[QUO_W-2:0], fits};
		end
	end

	// Output register holds a result until the receiver takes it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else begin
			out_valid_q <= load || (out_valid_q && out_stall);
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			distance_q <= load_dist;
			outcome_q  <= load_code;
		end
	end

	assign out_valid = out_valid_q;
	assign distance  = distance_q;
	assign outcome   = outcome_q;

	// After the first step the partial remainder stays below the divisor.
	a_rem_below_div: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DIV && step_q != '0) |-> (rem_q < {1'b0, div_q}))
		else $error("divider remainder out of range");

	// A result that is not a quotient carries zero distance.
	a_zero_when_special: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && outcome_q != OUT_COMPUTED) |-> (distance_q == '0))
		else $error("nonzero distance without a quotient");

	// A computed distance never exceeds one.
	a_dist_bounded: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && outcome_q == OUT_COMPUTED) |-> (distance_q <= ONE_FX))
		else $error("distance above one");

endmodule

`default_nettype wire

// ===== design/weighted_bernoulli_pair_distance.sv =====
// Top level of the weighted Bernoulli pair distance block: configuration
// register, front accumulator, pair queue and divider. Depends on wbpd_pkg.
//
// Use: stream the columns of one read pair on the input channel, one
// transfer per column, with last_column set on the final one. Each column
// carries both Q1.16 probabilities and their missing flags. On the last
// column the block returns one transfer on the output channel: the distance
// (Q1.16, saturated at 1.0) and an outcome code; the distance is zero unless
// the outcome is "computed". The minimum number of common columns is set
// through the APB port at address 0 and reads back there.
// Throughput: one column per cycle while the input is not stalled. A
// diagonal, too-few or zero-weight pair is resolved without the divider;
// a computed one goes through the 17-step bit-serial divider. A pair
// queue of two entries lets columns of following pairs keep streaming while
// the divider works; with two pairs waiting, the input stalls on the next
// last column until the divider frees an entry.
// Reset clears the sums, the queue and the output register and sets the
// minimum to one. While the receiver stalls, the result holds unchanged.
`default_nettype none

module weighted_bernoulli_pair_distance (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [wbpd_pkg::ADDR_W-1:0] paddr,
	input  logic [wbpd_pkg::DATA_W-1:0] pwdata,
	output logic [wbpd_pkg::DATA_W-1:0] prdata,
	output logic                        pready,
	input  logic                        in_valid,
	output logic                        in_stall,
	input  logic [wbpd_pkg::PROB_W-1:0] prob_first,
	input  logic [wbpd_pkg::PROB_W-1:0] prob_second,
	input  logic                        first_missing,
	input  logic                        second_missing,
	input  logic                        same_read,
	input  logic                        last_column,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [wbpd_pkg::PROB_W-1:0] distance,
	output logic [1:0]                  outcome
);
	import wbpd_pkg::*;

	logic [COUNT_W-1:0] common_floor_q;
	logic               reg_hit;
	logic               push, q_full, q_pop, q_valid;
	pair_sums_t         push_data, pop_data;

	// Configuration register.
	assign pready  = 1'b1;
	assign reg_hit = (paddr[ADDR_W-1:2] == REG_COMMON_FLOOR);
	assign prdata  = reg_hit ? DATA_W'(common_floor_q) : '0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			common_floor_q <= COMMON_FLOOR_RESET;
		end else if (psel && penable && pwrite && pready && reg_hit) begin
			common_floor_q <= pwdata[COUNT_W-1:0];
		end
	end

	wbpd_front u_front (
		.clk            (clk),
		.arst_n         (arst_n),
		.in_valid       (in_valid),
		.in_stall       (in_stall),
		.prob_first     (prob_first),
		.prob_second    (prob_second),
		.first_missing  (first_missing),
		.second_missing (second_missing),
		.same_read      (same_read),
		.last_column    (last_column),
		.push           (push),
		.push_data      (push_data),
		.q_full         (q_full)
	);

	wbpd_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (push),
		.push_data (push_data),
		.full      (q_full),
		.pop       (q_pop),
		.pop_valid (q_valid),
		.pop_data  (pop_data)
	);

	wbpd_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_valid      (q_valid),
		.q_data       (pop_data),
		.q_pop        (q_pop),
		.common_floor (common_floor_q),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.distance     (distance),
		.outcome      (outcome)
	);

endmodule

`default_nettype wire

// ===== tb/sv/tb.sv =====
// Self-checking testbench of the weighted Bernoulli pair distance block.
// Depends on wbpd_pkg and weighted_bernoulli_pair_distance. A tracker class
// mirrors the pair sums and checks each distance that the block returns.

module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import wbpd_pkg::*;

	localparam logic [ADDR_W-1:0] FLOOR_ADDR = ADDR_W'(4 * REG_COMMON_FLOOR);
	localparam logic [PROB_W-1:0] HALF_FX = ONE_FX >> 1;
	localparam int MAX_REPORTS = 10;
	localparam int SETTLE_CYCLES = 40;
	localparam int HOLD_CYCLES = 300;
	localparam int MAX_FLOOR = 4096;
	localparam int LONG_FLOOR = 48;

	// One column of a read pair, as it crosses the input channel.
	typedef struct packed {
		logic [PROB_W-1:0] prob_a;
		logic [PROB_W-1:0] prob_b;
		logic              miss_a;
		logic              miss_b;
		logic              diag;
		logic              last;
	} column_t;

	// One result of a read pair.
	typedef struct packed {
		logic [PROB_W-1:0] distance_fx;
		outcome_t          code;
	} distance_t;

	typedef enum {SINK_RANDOM, SINK_READY, SINK_HOLD} sink_mode_t;
	typedef enum {PAIR_PLAIN, PAIR_DIAGONAL, PAIR_FLAT, PAIR_SPARSE} pair_shape_t;

	// Running sums of the current read pair and the distances still owed.
	class pair_distance_tracker;
		logic [COUNT_W-1:0] common_floor;
		logic [COUNT_W-1:0] common_count;
		logic [SUM_W-1:0]   weight_sum;
		logic [SUM_W-1:0]   delta_sum;
		distance_t          pending_distances[$];
		int                 failures;

		function new();
			common_floor = COMMON_FLOOR_RESET;
			failures = 0;
			clear_sums();
		endfunction

		function void clear_sums();
			common_count = '0;
			weight_sum = '0;
			delta_sum = '0;
		endfunction

		function logic [PROB_W-1:0] clamp_prob(logic [PROB_W-1:0] p);
			return (p > ONE_FX) ? ONE_FX : p;
		endfunction

		// Weight |2p-1| of a clamped probability.
		function bit [63:0] weight(logic [PROB_W-1:0] p);
			bit [63:0] twice;
			twice = 64'(p) << 1;
			return (twice >= ONE_FX) ? twice - ONE_FX : ONE_FX - twice;
		endfunction

		function logic [SUM_W-1:0] add_saturated(logic [SUM_W-1:0] acc, bit [63:0] inc);
			bit [63:0] s;
			s = 64'(acc) + inc;
			return (s > SUM_MAX) ? SUM_MAX : s[SUM_W-1:0];
		endfunction

		function int pending();
			return pending_distances.size();
		endfunction

		function void report(string msg);
			failures++;
			if (failures <= MAX_REPORTS)
				$display("%0t mismatch: %s", $time, msg);
		endfunction

		// Accumulate one accepted column; a last column yields one distance.
		function void take_column(column_t c);
			bit [63:0] pa, pb, ww, prod2, delta, term, quotient;
			distance_t res;
			pa = 64'(clamp_prob(c.prob_a));
			pb = 64'(clamp_prob(c.prob_b));
			if (!c.miss_a && !c.miss_b) begin
				ww = (weight(pa[PROB_W-1:0]) * weight(pb[PROB_W-1:0])) >> FRAC_BITS;
				prod2 = ((pa * pb) >> FRAC_BITS) << 1;
				delta = (pa + pb >= prod2) ? pa + pb - prod2 : 64'd0;
				if (delta > ONE_FX)
					delta = ONE_FX;
				term = (ww * delta) >> FRAC_BITS;
				if (common_count != COUNT_MAX)
					common_count++;
				weight_sum = add_saturated(weight_sum, ww);
				delta_sum = add_saturated(delta_sum, term);
			end
			if (c.last) begin
				res.distance_fx = '0;
				// The diagonal flag outranks every other reason.
				if (c.diag) begin
					res.code = OUT_DIAGONAL;
				end else if (common_count < common_floor) begin
					res.code = OUT_TOO_FEW;
				end else if (weight_sum == '0) begin
					res.code = OUT_ZERO_WEIGHT;
				end else begin
					quotient = (64'(delta_sum) << FRAC_BITS) / 64'(weight_sum);
					res.distance_fx = (quotient > ONE_FX) ? ONE_FX : quotient[PROB_W-1:0];
					res.code = OUT_COMPUTED;
				end
				pending_distances.insert(pending_distances.size(), res);
				clear_sums();
			end
		endfunction

		// Compare one accepted result with the oldest owed distance.
		function void match_result(logic [PROB_W-1:0] got_distance, logic [1:0] got_code);
			distance_t want;
			if (pending_distances.size() == 0) begin
				report($sformatf("unexpected result distance %0d outcome %0d",
					got_distance, got_code));
				return;
			end
			want = pending_distances.pop_front();
			if (got_distance !== want.distance_fx || got_code !== want.code)
				report($sformatf("distance expected %0d got %0d, outcome expected %s got %0d",
					want.distance_fx, got_distance, want.code.name(), got_code));
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [ADDR_W-1:0] paddr;
	logic [DATA_W-1:0] pwdata;
	logic [DATA_W-1:0] prdata;
	logic pready;
	logic in_valid;
	logic in_stall;
	logic [PROB_W-1:0] prob_first;
	logic [PROB_W-1:0] prob_second;
	logic first_missing;
	logic second_missing;
	logic same_read;
	logic last_column;
	logic out_valid;
	logic out_stall;
	logic [PROB_W-1:0] distance;
	logic [1:0] outcome;

	pair_distance_tracker tracker = new();
	sink_mode_t sink_mode = SINK_RANDOM;
	bit source_gaps = 1'b1;

	weighted_bernoulli_pair_distance dut (.*);

	always #1 clk = ~clk;

	// Check every result transfer; the handshake is sampled at the falling edge
	// before the rising edge that takes it.
	always @(negedge clk) begin
		if (arst_n === 1'b1 && out_valid === 1'b1 && out_stall === 1'b0)
			tracker.match_result(distance, outcome);
	end

	// Receiver: random stall bursts, a long hold on request, or always ready.
	initial begin
		wait (arst_n === 1'b1);
		@(posedge clk);
		forever begin
			case (sink_mode)
				SINK_HOLD: begin
					out_stall <= 1'b1;
					repeat (HOLD_CYCLES) @(posedge clk);
					out_stall <= 1'b0;
					sink_mode = SINK_RANDOM;
					@(posedge clk);
				end
				SINK_RANDOM: begin
					out_stall <= 1'b1;
					repeat ($urandom_range(1, 9)) @(posedge clk);
					out_stall <= 1'b0;
					repeat ($urandom_range(1, 30)) @(posedge clk);
				end
				default: begin
					out_stall <= 1'b0;
					@(posedge clk);
				end
			endcase
		end
	end

	// Run limit, far above the slowest correct run.
	initial begin
		#2_000_000;
		$display("TB_ERROR");
		$finish;
	end

	// One APB transfer to the minimum-common register.
	task automatic apb_access(input logic write, input logic [DATA_W-1:0] wdata,
			output logic [DATA_W-1:0] rdata);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= write;
		paddr <= FLOOR_ADDR;
		pwdata <= wdata;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (pready !== 1'b1);
		rdata = prdata;
		psel <= 1'b0;
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
	endtask

	task automatic check_common_floor(input int value);
		logic [DATA_W-1:0] readback;
		apb_access(1'b0, '0, readback);
		if (readback !== DATA_W'(value))
			tracker.report($sformatf("min_common_columns reads %0d, expected %0d",
				readback, value));
	endtask

	task automatic set_common_floor(input int value);
		logic [DATA_W-1:0] unused;
		apb_access(1'b1, DATA_W'(value), unused);
		tracker.common_floor = COUNT_W'(value);
		check_common_floor(value);
	endtask

	// Offer one column and hold it until the block takes it. The stall is
	// sampled at the falling edge, where it is settled for the next rising one.
	task automatic send_column(input column_t c);
		logic stalled;
		in_valid <= 1'b1;
		prob_first <= c.prob_a;
		prob_second <= c.prob_b;
		first_missing <= c.miss_a;
		second_missing <= c.miss_b;
		same_read <= c.diag;
		last_column <= c.last;
		do begin
			@(negedge clk);
			stalled = (in_stall !== 1'b0);
			@(posedge clk);
		end while (stalled);
		tracker.take_column(c);
		if (source_gaps && $urandom_range(0, 3) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 9)) @(posedge clk);
		end
	endtask

	function automatic column_t make_column(input logic [PROB_W-1:0] a, b,
			input bit miss_a, miss_b, diag, last);
		column_t c;
		c.prob_a = a;
		c.prob_b = b;
		c.miss_a = miss_a;
		c.miss_b = miss_b;
		c.diag = diag;
		c.last = last;
		return c;
	endfunction

	// Probabilities weighted toward the corners, the zero-weight midpoint
	// and values above one.
	function automatic logic [PROB_W-1:0] random_prob();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return ONE_FX;
			2: return HALF_FX;
			3: return PROB_W'($urandom_range(ONE_FX + 1, (1 << PROB_W) - 1));
			default: return PROB_W'($urandom_range(0, ONE_FX));
		endcase
	endfunction

	task automatic send_pair(input pair_shape_t shape, input int len);
		column_t c;
		int miss_pct;
		case (shape)
			PAIR_SPARSE: miss_pct = 70;
			PAIR_FLAT: miss_pct = 20;
			default: miss_pct = 10;
		endcase
		for (int i = 0; i < len; i++) begin
			c.prob_a = (shape == PAIR_FLAT) ? HALF_FX : random_prob();
			c.prob_b = random_prob();
			c.miss_a = $urandom_range(0, 99) < miss_pct;
			c.miss_b = $urandom_range(0, 99) < miss_pct;
			c.last = (i == len - 1);
			c.diag = c.last ? (shape == PAIR_DIAGONAL) : 1'($urandom_range(0, 1));
			send_column(c);
		end
	endtask

	// Whole read pairs of random shape until about the given column count.
	task automatic random_pairs(input int columns);
		int sent;
		int len;
		pair_shape_t shape;
		sent = 0;
		while (sent < columns) begin
			case ($urandom_range(0, 19))
				0: shape = PAIR_DIAGONAL;
				1: shape = PAIR_FLAT;
				2, 3: shape = PAIR_SPARSE;
				default: shape = PAIR_PLAIN;
			endcase
			len = ($urandom_range(0, 15) == 0) ? $urandom_range(13, 48) : $urandom_range(1, 12);
			send_pair(shape, len);
			sent += len;
		end
	endtask

	// A long pair; corner columns give the largest weight and delta.
	task automatic long_pair(input int len, input int missing_at, input bit corner);
		column_t c;
		for (int i = 0; i < len; i++) begin
			c = make_column(corner ? '0 : random_prob(), corner ? ONE_FX : random_prob(),
				i == missing_at, 1'b0, 1'($urandom_range(0, 1)), i == len - 1);
			if (c.last)
				c.diag = 1'b0;
			send_column(c);
		end
	endtask

	// Let every owed distance arrive, then give the block time to go quiet.
	task automatic wait_idle();
		in_valid <= 1'b0;
		while (tracker.pending() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Main sequence.
	initial begin
		arst_n = 1'b0;
		psel = 1'b0;
		penable = 1'b0;
		pwrite = 1'b0;
		paddr = '0;
		pwdata = '0;
		in_valid = 1'b0;
		prob_first = '0;
		prob_second = '0;
		first_missing = 1'b0;
		second_missing = 1'b0;
		same_read = 1'b0;
		last_column = 1'b0;
		out_stall = 1'b0;
		repeat (7) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		check_common_floor(COMMON_FLOOR_RESET);

		// Directed columns: corners, clamping, missing values, diagonal, zero weight.
		send_column(make_column('0, ONE_FX, 0, 0, 0, 1));
		send_column(make_column('0, '0, 0, 0, 0, 1));
		send_column(make_column('1, '0, 0, 0, 0, 1));
		send_column(make_column(ONE_FX, ONE_FX, 0, 0, 0, 1));
		send_column(make_column(HALF_FX, '0, 0, 0, 0, 1));
		send_column(make_column(ONE_FX, '0, 1, 0, 0, 1));
		send_column(make_column(ONE_FX, '0, 0, 1, 0, 1));
		send_column(make_column('1, '1, 1, 1, 0, 1));
		send_column(make_column('0, ONE_FX, 0, 0, 1, 1));
		send_column(make_column('1, '1, 1, 1, 1, 1));
		send_column(make_column(PROB_W'(1000), PROB_W'(60000), 0, 0, 0, 0));
		send_column(make_column(PROB_W'(65537), PROB_W'(20000), 0, 1, 1, 0));
		send_column(make_column(PROB_W'(40000), PROB_W'(12345), 0, 0, 0, 1));
		send_column(make_column(ONE_FX, '0, 0, 0, 1, 0));
		send_column(make_column(PROB_W'(65535), PROB_W'(1), 0, 0, 0, 1));
		send_column(make_column(HALF_FX, HALF_FX, 0, 0, 0, 0));
		send_column(make_column(HALF_FX, PROB_W'(7), 0, 0, 0, 1));
		send_column(make_column(PROB_W'(1), PROB_W'(65535), 0, 0, 0, 0));
		send_column(make_column(PROB_W'(98304), PROB_W'(32767), 0, 0, 0, 1));
		wait_idle();

		// No minimum: a pair with no common column has zero weight.
		set_common_floor(0);
		send_column(make_column('0, '0, 1, 1, 0, 1));
		random_pairs(300);
		wait_idle();

		// Minimum of 4096: every pair that is not diagonal has too few columns.
		set_common_floor(MAX_FLOOR);
		random_pairs(30);
		wait_idle();

		// Long pairs above, at and just under a raised minimum.
		set_common_floor(LONG_FLOOR);
		long_pair(LONG_FLOOR + 16, -1, 1'b1);
		long_pair(LONG_FLOOR, -1, 1'b0);
		long_pair(LONG_FLOOR, $urandom_range(0, LONG_FLOOR - 1), 1'b0);
		random_pairs(50);
		wait_idle();

		// Receiver holds off while short pairs keep coming, filling the pair queue.
		set_common_floor(3);
		source_gaps = 1'b0;
		sink_mode = SINK_HOLD;
		for (int i = 0; i < 40; i++)
			send_pair(PAIR_PLAIN, $urandom_range(1, 3));
		source_gaps = 1'b1;
		random_pairs(220);
		wait_idle();

		// Back to the reset minimum; the closing stretch runs at full rate.
		set_common_floor(1);
		random_pairs(250);
		source_gaps = 1'b0;
		sink_mode = SINK_READY;
		random_pairs(150);
		wait_idle();

		if (tracker.failures == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

// ===== sim.f =====
design/wbpd_pkg.sv
design/wbpd_front.sv
design/wbpd_queue.sv
design/wbpd_back.sv
design/weighted_bernoulli_pair_distance.sv
tb/sv/tb.sv
